[rtl/assert_macros.svh]
// Assertion macros used by the top-level parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/hrlp_pkg.sv]
`default_nettype none

package hrlp_pkg;

  // Default circular buffer size that offsets are taken modulo.
  localparam int BUFFER_SIZE_DEF = 4096;

  // Field widths of one result beat.
  localparam int OFF_W = 12;
  localparam int VER_W = 10;

  localparam logic [VER_W-1:0] VER_MAX = 10'd999;

  // Characters the recogniser looks for.
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_1     = "1";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_E     = "E";
  localparam logic [7:0] CH_G     = "G";
  localparam logic [7:0] CH_H     = "H";
  localparam logic [7:0] CH_O     = "O";
  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_T     = "T";

  typedef enum logic [3:0] {
    PS_START,
    PS_METHOD,
    PS_SP_BEFORE_URI,
    PS_URI,
    PS_HTTP,
    PS_H,
    PS_HT,
    PS_HTT,
    PS_HTTP_SLASH,
    PS_FIRST_MAJOR,
    PS_MAJOR,
    PS_FIRST_MINOR,
    PS_MINOR,
    PS_SP_AFTER,
    PS_ALMOST
  } pstate_t;

  typedef enum logic [1:0] {
    STAT_NEED_MORE   = 2'd0,
    STAT_DONE        = 2'd1,
    STAT_BAD_METHOD  = 2'd2,
    STAT_BAD_REQUEST = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    METH_UNKNOWN = 2'd0,
    METH_GET     = 2'd1,
    METH_POST    = 2'd2,
    METH_HEAD    = 2'd3
  } meth_t;

  // One result beat.
  typedef struct packed {
    stat_t             status;
    meth_t             method_code;
    logic [VER_W-1:0]  version_major;
    logic [VER_W-1:0]  version_minor;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  method_end_offset;
    logic [OFF_W-1:0]  uri_start_offset;
    logic [OFF_W-1:0]  uri_end_offset;
    logic [OFF_W-1:0]  end_offset;
  } res_t;

endpackage

`default_nettype wire

[rtl/hrlp_fsm.sv]
`default_nettype none

module hrlp_fsm #(
  parameter int BUFFER_SIZE = hrlp_pkg::BUFFER_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic [7:0]    data_byte,
  output hrlp_pkg::res_t     res
);

  localparam int PW    = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
  localparam int OFF_W = hrlp_pkg::OFF_W;
  localparam int VER_W = hrlp_pkg::VER_W;
  localparam logic [PW-1:0] POS_LAST = PW'(BUFFER_SIZE - 1);

  // Multiply by ten and add a digit, saturating at the version limit.
  function automatic logic [VER_W-1:0] ver_step(input logic [VER_W-1:0] acc,
                                                input logic [7:0] ch);
    logic [VER_W+3:0] sum;
    logic [7:0]       dig;
    dig = ch - hrlp_pkg::CH_0;
    sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{(VER_W-4){1'b0}}, dig};
    ver_step = (sum > {4'd0, hrlp_pkg::VER_MAX}) ? hrlp_pkg::VER_MAX : sum[VER_W-1:0];
  endfunction

  hrlp_pkg::pstate_t    state_r, state_s, state_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [3:0][7:0]      mchars_r, mchars_s, mchars_nxt;
  logic [2:0]           mlen_r, mlen_s, mlen_nxt;
  hrlp_pkg::meth_t      mclass_r, mclass_s, mclass_nxt;
  logic [VER_W-1:0]     major_r, major_s, major_nxt;
  logic [VER_W-1:0]     minor_r, minor_s, minor_nxt;
  logic [OFF_W-1:0]     start_r, start_s, start_nxt;
  logic [OFF_W-1:0]     mend_r, mend_s, mend_nxt;
  logic [OFF_W-1:0]     ustart_r, ustart_s, ustart_nxt;
  logic [OFF_W-1:0]     uend_r, uend_s, uend_nxt;
  logic [OFF_W-1:0]     end_r, end_s, end_nxt;
  logic                 eseen_r, eseen_s, eseen_nxt;
  hrlp_pkg::stat_t      status;

  logic [PW+OFF_W-1:0]  pos_ext, prev_ext;
  logic [PW-1:0]        prev_pos;
  logic [OFF_W-1:0]     pos_off, prev_off;
  logic                 is_upper, is_digit, is_sp;

  // Current and previous buffer offsets, wrapped and cut to the offset width.
  always_comb begin
    prev_pos = (pos_r == '0) ? POS_LAST : pos_r - PW'(1);
    pos_ext  = {{OFF_W{1'b0}}, pos_r};
    prev_ext = {{OFF_W{1'b0}}, prev_pos};
    pos_off  = pos_ext[OFF_W-1:0];
    prev_off = prev_ext[OFF_W-1:0];
    pos_nxt  = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
  end

  assign is_upper = (data_byte >= hrlp_pkg::CH_A) && (data_byte <= hrlp_pkg::CH_Z);
  assign is_digit = (data_byte >= hrlp_pkg::CH_0) && (data_byte <= hrlp_pkg::CH_9);
  assign is_sp    = (data_byte == hrlp_pkg::CH_SP);

  // Recogniser step: next state, captured fields and the beat status.
  always_comb begin
    state_s  = state_r;
    mchars_s = mchars_r;
    mlen_s   = mlen_r;
    mclass_s = mclass_r;
    major_s  = major_r;
    minor_s  = minor_r;
    start_s  = start_r;
    mend_s   = mend_r;
    ustart_s = ustart_r;
    uend_s   = uend_r;
    end_s    = end_r;
    eseen_s  = eseen_r;
    status   = hrlp_pkg::STAT_NEED_MORE;

    unique case (state_r)
      hrlp_pkg::PS_START: begin
        start_s = pos_off;
        if (data_byte == hrlp_pkg::CH_CR || data_byte == hrlp_pkg::CH_LF) begin
          state_s = hrlp_pkg::PS_START;
        end else if (!is_upper && !is_sp) begin
          status = hrlp_pkg::STAT_BAD_METHOD;
        end else begin
          mchars_s = {24'd0, data_byte};
          mlen_s   = 3'd1;
          state_s  = hrlp_pkg::PS_METHOD;
        end
      end
      hrlp_pkg::PS_METHOD: begin
        if (is_sp) begin
          mend_s   = pos_off;
          mclass_s = hrlp_pkg::METH_UNKNOWN;
          if (mlen_r == 3'd3) begin
            if (mchars_r[0] == hrlp_pkg::CH_G && mchars_r[1] == hrlp_pkg::CH_E &&
                mchars_r[2] == hrlp_pkg::CH_T) begin
              mclass_s = hrlp_pkg::METH_GET;
            end
          end else if (mlen_r == 3'd4) begin
            if (mchars_r[0] == hrlp_pkg::CH_P && mchars_r[1] == hrlp_pkg::CH_O &&
                mchars_r[2] == hrlp_pkg::CH_S && mchars_r[3] == hrlp_pkg::CH_T) begin
              mclass_s = hrlp_pkg::METH_POST;
            end else if (mchars_r[0] == hrlp_pkg::CH_H && mchars_r[1] == hrlp_pkg::CH_E &&
                         mchars_r[2] == hrlp_pkg::CH_A && mchars_r[3] == hrlp_pkg::CH_D) begin
              mclass_s = hrlp_pkg::METH_HEAD;
            end
          end
          state_s = hrlp_pkg::PS_SP_BEFORE_URI;
        end else if (!is_upper) begin
          status = hrlp_pkg::STAT_BAD_METHOD;
        end else begin
          // Only the first four letters are kept; the length saturates at seven.
          if (mlen_r < 3'd4) mchars_s[mlen_r[1:0]] = data_byte;
          if (mlen_r < 3'd7) mlen_s = mlen_r + 3'd1;
        end
      end
      hrlp_pkg::PS_SP_BEFORE_URI: begin
        if (data_byte == hrlp_pkg::CH_SLASH) begin
          ustart_s = pos_off;
          state_s  = hrlp_pkg::PS_URI;
        end else if (!is_sp) begin
          status = hrlp_pkg::STAT_BAD_REQUEST;
        end
      end
      hrlp_pkg::PS_URI: begin
        if (is_sp) begin
          uend_s  = pos_off;
          state_s = hrlp_pkg::PS_HTTP;
        end
      end
      hrlp_pkg::PS_HTTP: begin
        if (data_byte == hrlp_pkg::CH_H) state_s = hrlp_pkg::PS_H;
        else if (!is_sp) status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_H: begin
        if (data_byte == hrlp_pkg::CH_T) state_s = hrlp_pkg::PS_HT;
        else status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_HT: begin
        if (data_byte == hrlp_pkg::CH_T) state_s = hrlp_pkg::PS_HTT;
        else status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_HTT: begin
        if (data_byte == hrlp_pkg::CH_P) state_s = hrlp_pkg::PS_HTTP_SLASH;
        else status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_HTTP_SLASH: begin
        if (data_byte == hrlp_pkg::CH_SLASH) state_s = hrlp_pkg::PS_FIRST_MAJOR;
        else status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_FIRST_MAJOR: begin
        if (data_byte < hrlp_pkg::CH_1 || data_byte > hrlp_pkg::CH_9) begin
          status = hrlp_pkg::STAT_BAD_REQUEST;
        end else begin
          major_s = ver_step('0, data_byte);
          state_s = hrlp_pkg::PS_MAJOR;
        end
      end
      hrlp_pkg::PS_MAJOR: begin
        if (data_byte == hrlp_pkg::CH_DOT) state_s = hrlp_pkg::PS_FIRST_MINOR;
        else if (!is_digit) status = hrlp_pkg::STAT_BAD_REQUEST;
        else major_s = ver_step(major_r, data_byte);
      end
      hrlp_pkg::PS_FIRST_MINOR: begin
        if (!is_digit) begin
          status = hrlp_pkg::STAT_BAD_REQUEST;
        end else begin
          minor_s = ver_step('0, data_byte);
          state_s = hrlp_pkg::PS_MINOR;
        end
      end
      hrlp_pkg::PS_MINOR: begin
        if (data_byte == hrlp_pkg::CH_CR) state_s = hrlp_pkg::PS_ALMOST;
        else if (data_byte == hrlp_pkg::CH_LF) status = hrlp_pkg::STAT_DONE;
        else if (is_sp) state_s = hrlp_pkg::PS_SP_AFTER;
        else if (!is_digit) status = hrlp_pkg::STAT_BAD_REQUEST;
        else minor_s = ver_step(minor_r, data_byte);
      end
      hrlp_pkg::PS_SP_AFTER: begin
        if (data_byte == hrlp_pkg::CH_CR) state_s = hrlp_pkg::PS_ALMOST;
        else if (data_byte == hrlp_pkg::CH_LF) status = hrlp_pkg::STAT_DONE;
        else if (!is_sp) status = hrlp_pkg::STAT_BAD_REQUEST;
      end
      hrlp_pkg::PS_ALMOST: begin
        // The CR was the previous byte; its offset is reported even on error.
        end_s   = prev_off;
        eseen_s = 1'b1;
        status  = (data_byte == hrlp_pkg::CH_LF) ? hrlp_pkg::STAT_DONE
                                                 : hrlp_pkg::STAT_BAD_REQUEST;
      end
      default: begin
        status = hrlp_pkg::STAT_BAD_REQUEST;
      end
    endcase

    // A line ended by a lone LF takes the LF's offset.
    if (status == hrlp_pkg::STAT_DONE && !eseen_s) end_s = pos_off;
  end

  // Result beat from the updated fields.
  always_comb begin
    res.status            = status;
    res.method_code       = mclass_s;
    res.version_major     = major_s;
    res.version_minor     = minor_s;
    res.start_offset      = start_s;
    res.method_end_offset = mend_s;
    res.uri_start_offset  = ustart_s;
    res.uri_end_offset    = uend_s;
    res.end_offset        = end_s;
  end

  // After a finished line or an error, all but the position returns to reset.
  always_comb begin
    if (status != hrlp_pkg::STAT_NEED_MORE) begin
      state_nxt  = hrlp_pkg::PS_START;
      mchars_nxt = '0;
      mlen_nxt   = '0;
      mclass_nxt = hrlp_pkg::METH_UNKNOWN;
      major_nxt  = '0;
      minor_nxt  = '0;
      start_nxt  = '0;
      mend_nxt   = '0;
      ustart_nxt = '0;
      uend_nxt   = '0;
      end_nxt    = '0;
      eseen_nxt  = 1'b0;
    end else begin
      state_nxt  = state_s;
      mchars_nxt = mchars_s;
      mlen_nxt   = mlen_s;
      mclass_nxt = mclass_s;
      major_nxt  = major_s;
      minor_nxt  = minor_s;
      start_nxt  = start_s;
      mend_nxt   = mend_s;
      ustart_nxt = ustart_s;
      uend_nxt   = uend_s;
      end_nxt    = end_s;
      eseen_nxt  = eseen_s;
    end
  end

  // Recogniser state, advanced once per beat that moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hrlp_pkg::PS_START;
      pos_r    <= '0;
      mchars_r <= '0;
      mlen_r   <= '0;
      mclass_r <= hrlp_pkg::METH_UNKNOWN;
      major_r  <= '0;
      minor_r  <= '0;
      start_r  <= '0;
      mend_r   <= '0;
      ustart_r <= '0;
      uend_r   <= '0;
      end_r    <= '0;
      eseen_r  <= 1'b0;
    end else if (step_en) begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      mchars_r <= mchars_nxt;
      mlen_r   <= mlen_nxt;
      mclass_r <= mclass_nxt;
      major_r  <= major_nxt;
      minor_r  <= minor_nxt;
      start_r  <= start_nxt;
      mend_r   <= mend_nxt;
      ustart_r <= ustart_nxt;
      uend_r   <= uend_nxt;
      end_r    <= end_nxt;
      eseen_r  <= eseen_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/http_request_line_parser.sv]
// Channel   Direction  Ports
// in_       input      in_valid, in_ready, in_data_byte
// out_      output     out_valid, out_ready, out_status, out_method_code,
//                      out_version_major/minor, out_*_offset
//
// Every input beat gives exactly one result beat, by way of the input and
// output registers; one beat is taken per cycle while the output is drained.
// The rate is set by the single recogniser step between the input register
// and the output register. Reset (rst_n low, synchronous) empties both
// registers and returns the recogniser to its start state at offset zero.
// A stalled output holds its beat; the input register keeps taking a beat
// whenever the beat it holds moves on in the same cycle.
`default_nettype none

module http_request_line_parser #(
  parameter int BUFFER_SIZE = hrlp_pkg::BUFFER_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_data_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [1:0]                        out_method_code,
  output logic [hrlp_pkg::VER_W-1:0]        out_version_major,
  output logic [hrlp_pkg::VER_W-1:0]        out_version_minor,
  output logic [hrlp_pkg::OFF_W-1:0]        out_start_offset,
  output logic [hrlp_pkg::OFF_W-1:0]        out_method_end_offset,
  output logic [hrlp_pkg::OFF_W-1:0]        out_uri_start_offset,
  output logic [hrlp_pkg::OFF_W-1:0]        out_uri_end_offset,
  output logic [hrlp_pkg::OFF_W-1:0]        out_end_offset
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_byte_r;
  logic            out_valid_r, out_valid_nxt;
  hrlp_pkg::res_t  res_r;
  hrlp_pkg::res_t  step_res;
  logic            advance;

  // A beat moves on when the output register is empty or being emptied.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : ((out_ready) ? 1'b0 : out_valid_r);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_valid && in_ready) s1_byte_r <= in_data_byte;
  end

  hrlp_fsm #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (s1_byte_r),
    .res       (step_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) res_r <= step_res;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_r.status;
  assign out_method_code       = res_r.method_code;
  assign out_version_major     = res_r.version_major;
  assign out_version_minor     = res_r.version_minor;
  assign out_start_offset      = res_r.start_offset;
  assign out_method_end_offset = res_r.method_end_offset;
  assign out_uri_start_offset  = res_r.uri_start_offset;
  assign out_uri_end_offset    = res_r.uri_end_offset;
  assign out_end_offset        = res_r.end_offset;

`include "assert_macros.svh"

  // A finished line always carries a non-zero major version.
  `ASSERT_SAME(a_done_major, clk, rst_n, out_valid_r && res_r.status == hrlp_pkg::STAT_DONE, res_r.version_major != '0)
  // A bad method is reported before any method is classed.
  `ASSERT_SAME(a_badmeth_cls, clk, rst_n, out_valid_r && res_r.status == hrlp_pkg::STAT_BAD_METHOD, res_r.method_code == hrlp_pkg::METH_UNKNOWN)
  // A beat handed on always lands in the output register.
  `ASSERT_NEXT(a_adv_lands, clk, rst_n, advance, out_valid_r)
  // A held input beat keeps its byte while it waits.
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r && $stable(s1_byte_r))

endmodule

`default_nettype wire
